### src/lgs_pkg.sv
// Package for the life grid generation step block.
// Holds transaction types, field widths, op and register codes, and defaults.
// No dependencies.
package lgs_pkg;

  localparam int LGS_MAX_WIDTH  = 64;
  localparam int LGS_MAX_HEIGHT = 64;

  localparam int OP_W      = 2;
  localparam int ROW_W     = 6;
  localparam int COL_W     = 6;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_STEP  = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACTIVE_WIDTH  = 1'd0,
    CFG_ACTIVE_HEIGHT = 1'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_STEP
  } state_e;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             write_value;
  } in_item_t;

  typedef struct packed {
    logic cell_value;
    logic out_of_range;
  } out_item_t;

endpackage

### src/life_grid_generation_step.sv
// Top level of the life grid generation step block (B3/S23, no wraparound).
// Depends on lgs_pkg, lgs_ram and lgs_row_eval.
//
// After reset the grid is cleared one row per cycle with busy high. For a cell
// write, cell read or unused op the row is read from the grid RAM at accept, and
// done_o strobes the result in the following cycle, together with the write-back
// of a modified row. In a generation step the RAM's single read port streams one
// row per cycle through a three-row window, each new row is written back once the
// row below it has been read, and done_o strobes in the last cycle. The receiver
// cannot stall: each result is on result_o for exactly one cycle and must be taken
// then.
module life_grid_generation_step #(
  parameter int MAX_WIDTH  = lgs_pkg::LGS_MAX_WIDTH,
  parameter int MAX_HEIGHT = lgs_pkg::LGS_MAX_HEIGHT
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  lgs_pkg::in_item_t            item_i,
  output logic                         done_o,
  output lgs_pkg::out_item_t           result_o,
  input  logic                         cfg_we_i,
  input  logic [lgs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [lgs_pkg::CFG_W-1:0]    cfg_data_i
);
  import lgs_pkg::*;

  localparam int AW    = $clog2(MAX_HEIGHT);
  localparam int CWI   = $clog2(MAX_WIDTH);
  localparam int CNT_W = $clog2(MAX_HEIGHT + 2);

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [CFG_W-1:0] act_w_q, act_h_q;
  logic [CFG_W-1:0] eff_w, eff_h;
  in_item_t         req_q;
  logic             oor_q, oor_d;
  logic [MAX_WIDTH-1:0] prev_q, prev_d, cur_q, cur_d, next_in, new_row;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [MAX_WIDTH-1:0] ram_wdata, ram_rdata;

  logic accept, step_last, clear_last;

  assign eff_w = (32'(act_w_q) > MAX_WIDTH)  ? CFG_W'(MAX_WIDTH)  : act_w_q;
  assign eff_h = (32'(act_h_q) > MAX_HEIGHT) ? CFG_W'(MAX_HEIGHT) : act_h_q;

  assign accept     = start && !busy;
  assign step_last  = (32'(cnt_q) == 32'(eff_h) + 32'd1);
  assign clear_last = (32'(cnt_q) == MAX_HEIGHT - 1);

  always_comb begin
    oor_d = ((item_i.op == OP_WRITE) || (item_i.op == OP_READ)) &&
            ((32'(item_i.row) >= 32'(eff_h)) || (32'(item_i.col) >= 32'(eff_w)));
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_CLEAR: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) begin
          cnt_d   = '0;
          state_d = (item_i.op == OP_STEP) ? ST_STEP : ST_ACCESS;
        end
      end
      ST_ACCESS: state_d = ST_IDLE;
      ST_STEP: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (step_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and RAM control
  always_comb begin
    busy      = 1'b1;
    done_o    = 1'b0;
    result_o  = '0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = AW'(cnt_q);
    ram_raddr = AW'(item_i.row);
    ram_wdata = '0;
    case (state_q)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        busy   = 1'b0;
        ram_re = start;
      end
      ST_ACCESS: begin
        done_o                = 1'b1;
        result_o.out_of_range = oor_q;
        if (!oor_q && (req_q.op == OP_READ)) begin
          result_o.cell_value = ram_rdata[CWI'(req_q.col)];
        end
        ram_waddr                  = AW'(req_q.row);
        ram_wdata                  = ram_rdata;
        ram_wdata[CWI'(req_q.col)] = req_q.write_value;
        ram_we                     = !oor_q && (req_q.op == OP_WRITE);
      end
      ST_STEP: begin
        done_o    = step_last;
        ram_re    = (32'(cnt_q) < 32'(eff_h));
        ram_raddr = AW'(cnt_q);
        ram_we    = (cnt_q >= CNT_W'(2));
        ram_waddr = AW'(cnt_q - CNT_W'(2));
        ram_wdata = new_row;
      end
      default: ;
    endcase
  end

  // row window
  always_comb begin
    next_in = (32'(cnt_q) <= 32'(eff_h)) ? ram_rdata : '0;
    prev_d  = prev_q;
    cur_d   = cur_q;
    if (accept) begin
      prev_d = '0;
      cur_d  = '0;
    end else if ((state_q == ST_STEP) && (cnt_q != '0)) begin
      prev_d = cur_q;
      cur_d  = next_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      cnt_q   <= '0;
      act_w_q <= CFG_W'(64);
      act_h_q <= CFG_W'(64);
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_WIDTH:  act_w_q <= cfg_data_i;
          CFG_ACTIVE_HEIGHT: act_h_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= item_i;
      oor_q <= oor_d;
    end
    prev_q <= prev_d;
    cur_q  <= cur_d;
  end

  lgs_ram #(
    .WIDTH (MAX_WIDTH),
    .DEPTH (MAX_HEIGHT)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  lgs_row_eval #(
    .WIDTH (MAX_WIDTH)
  ) u_row_eval (
    .prev_i  (prev_q),
    .cur_i   (cur_q),
    .next_i  (next_in),
    .eff_w_i (eff_w),
    .row_o   (new_row)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside a transaction");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy)
    else $error("accepted transaction did not raise busy");

  a_step_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_STEP) && ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("step writes a row it is still reading");

  a_oor_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.out_of_range) |-> !ram_we)
    else $error("out-of-range access modified the grid");

  a_step_result_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (state_q == ST_STEP)) |-> (result_o == '0))
    else $error("generation result not zero");

endmodule

### src/lgs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lgs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/lgs_row_eval.sv
// Next-generation evaluation of one grid row from the rows above, at and below.
// Columns beyond the active width count as dead and keep their old value.
// Depends on lgs_pkg.
module lgs_row_eval #(
  parameter int WIDTH = 64
) (
  input  logic [WIDTH-1:0]          prev_i,
  input  logic [WIDTH-1:0]          cur_i,
  input  logic [WIDTH-1:0]          next_i,
  input  logic [lgs_pkg::CFG_W-1:0] eff_w_i,
  output logic [WIDTH-1:0]          row_o
);
  import lgs_pkg::*;

  logic [WIDTH-1:0] mask;
  logic [WIDTH-1:0] nxt;
  logic [WIDTH+1:0] pm, cm, nm;

  always_comb begin
    for (int c = 0; c < WIDTH; c++) begin
      mask[c] = (c < int'(eff_w_i));
    end
  end

  assign pm = {1'b0, prev_i & mask, 1'b0};
  assign cm = {1'b0, cur_i  & mask, 1'b0};
  assign nm = {1'b0, next_i & mask, 1'b0};

  always_comb begin
    logic [3:0] n;
    n = '0;
    for (int c = 0; c < WIDTH; c++) begin
      n = 4'(pm[c]) + 4'(pm[c+1]) + 4'(pm[c+2])
        + 4'(cm[c]) + 4'(cm[c+2])
        + 4'(nm[c]) + 4'(nm[c+1]) + 4'(nm[c+2]);
      nxt[c] = (n == BIRTH_COUNT) || (cm[c+1] && (n == SURVIVE_COUNT));
    end
  end

  assign row_o = (nxt & mask) | (cur_i & ~mask);

endmodule

### tb/tb_life_grid_generation_step.sv
// Self-checking testbench for life_grid_generation_step (B3/S23 grid, no wraparound).
// Drives directed and random cell writes, reads and generation steps, checking each
// result against a shadow grid or a pinned value. Depends on lgs_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_life_grid_generation_step;
  import lgs_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int GRID_N = 64;

  typedef struct {
    bit         is_cfg;
    cfg_idx_e   reg_idx;
    logic [6:0] reg_val;
    in_item_t   item;
    bit         pinned;
    out_item_t  res;
  } dir_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  in_item_t             item_i;
  logic                 done_o;
  out_item_t            result_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  // pinned expectation travels with the item it belongs to
  logic      pin_flag;
  out_item_t pin_res;

  logic [GRID_N-1:0] shadow_grid [GRID_N];
  logic [6:0]        shadow_cols;
  logic [6:0]        shadow_rows;
  out_item_t         cell_results_q [$];

  int errors;
  int cycles;
  int n_writes, n_reads, n_steps, n_unused, n_oor, n_live_reads;
  bit steady;

  life_grid_generation_step dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  function automatic int eff_dim(logic [6:0] v);
    return (v > GRID_N) ? GRID_N : int'(v);
  endfunction

  // Applies one transaction to the shadow grid and returns the result it should produce.
  function automatic out_item_t predict_cell_op(in_item_t it);
    out_item_t         r;
    logic [GRID_N-1:0] old_gen [GRID_N];
    int                h, w, nb, rr, cc;
    logic              alive;
    r = '0;
    h = eff_dim(shadow_rows);
    w = eff_dim(shadow_cols);
    if (it.op == OP_WRITE || it.op == OP_READ) begin
      if (int'(it.row) >= h || int'(it.col) >= w) begin
        r.out_of_range = 1'b1;
      end else if (it.op == OP_WRITE) begin
        shadow_grid[it.row][it.col] = it.write_value;
      end else begin
        r.cell_value = shadow_grid[it.row][it.col];
      end
    end else if (it.op == OP_STEP) begin
      old_gen = shadow_grid;
      for (int r0 = 0; r0 < h; r0++) begin
        for (int c0 = 0; c0 < w; c0++) begin
          nb = 0;
          for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
              rr = r0 + dr;
              cc = c0 + dc;
              if ((dr != 0 || dc != 0) && rr >= 0 && rr < h && cc >= 0 && cc < w)
                nb += old_gen[rr][cc];
            end
          end
          alive = old_gen[r0][c0];
          shadow_grid[r0][c0] = alive ? (nb == 2 || nb == 3) : (nb == 3);
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (cell_results_q.size() == 0) begin
          errors++;
          $display("%0t: result with no transaction pending: actual %b", $time, result_o);
        end else begin
          want = cell_results_q.pop_front();
          if (result_o.cell_value !== want.cell_value) begin
            errors++;
            $display("%0t: cell_value mismatch: expected %b actual %b",
                     $time, want.cell_value, result_o.cell_value);
          end
          if (result_o.out_of_range !== want.out_of_range) begin
            errors++;
            $display("%0t: out_of_range mismatch: expected %b actual %b",
                     $time, want.out_of_range, result_o.out_of_range);
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_WIDTH:  shadow_cols = cfg_data_i;
          CFG_ACTIVE_HEIGHT: shadow_rows = cfg_data_i;
          default: ;
        endcase
      end
      if (start && !busy) begin
        want = predict_cell_op(item_i);
        if (pin_flag) want = pin_res;
        cell_results_q.insert(cell_results_q.size(), want);
        case (item_i.op)
          OP_WRITE: n_writes++;
          OP_READ:  n_reads++;
          OP_STEP:  n_steps++;
          default:  n_unused++;
        endcase
        if (want.out_of_range) n_oor++;
        if (want.cell_value) n_live_reads++;
      end
    end
  end

  function automatic dir_row_t dir_op(logic [OP_W-1:0] op, int r, int c, bit wv,
                                      bit pinned, bit cv, bit oor);
    dir_row_t d;
    d = '{reg_idx: CFG_ACTIVE_WIDTH, default: '0};
    d.item.op = op;
    d.item.row = r[ROW_W-1:0];
    d.item.col = c[COL_W-1:0];
    d.item.write_value = wv;
    d.pinned = pinned;
    d.res.cell_value = cv;
    d.res.out_of_range = oor;
    return d;
  endfunction

  function automatic dir_row_t dir_cfg(cfg_idx_e idx, int v);
    dir_row_t d;
    d = '{reg_idx: CFG_ACTIVE_WIDTH, default: '0};
    d.is_cfg = 1'b1;
    d.reg_idx = idx;
    d.reg_val = v[6:0];
    return d;
  endfunction

  task automatic issue(in_item_t it, bit pinned, out_item_t res);
    start <= 1'b1;
    item_i <= it;
    pin_flag <= pinned;
    pin_res <= res;
    do @(posedge clk_i); while (busy);
    if (!steady && $urandom_range(99) < 38) begin
      start <= 1'b0;
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 80)) @(posedge clk_i);
      else
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [6:0] val);
    start <= 1'b0;
    do @(posedge clk_i); while (cell_results_q.size() != 0 || busy);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    int       pick, h, w;
    h = eff_dim(shadow_rows);
    w = eff_dim(shadow_cols);
    it.row = ROW_W'($urandom_range(GRID_N - 1));
    it.col = COL_W'($urandom_range(GRID_N - 1));
    it.write_value = ($urandom_range(99) < 45);
    pick = $urandom_range(99);
    if (pick < 40)      it.op = OP_WRITE;
    else if (pick < 70) it.op = OP_READ;
    else if (pick < 90) it.op = OP_STEP;
    else if (pick < 95) it.op = OP_UNUSED;
    else                it.op = OP_W'($urandom_range(3));
    if (it.op != OP_STEP && h > 0 && w > 0 && $urandom_range(9) < 8) begin
      it.row = ROW_W'($urandom_range(h - 1));
      it.col = COL_W'($urandom_range(w - 1));
    end
    return it;
  endfunction

  initial begin
    dir_row_t  dir_rows [$];
    int        phase_cols [9];
    int        phase_rows [9];
    int        useful;
    in_item_t  it;
    rst_ni <= 1'b0;
    start <= 1'b0;
    item_i <= '0;
    pin_flag <= 1'b0;
    pin_res <= '0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CFG_ACTIVE_WIDTH;
    cfg_data_i <= '0;
    errors = 0;
    cycles = 0;
    steady = 0;
    shadow_cols = 7'd64;
    shadow_rows = 7'd64;
    foreach (shadow_grid[i]) shadow_grid[i] = '0;

    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,   0,  0, 0, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,  63, 63, 0, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_WRITE,  0,  0, 1, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_WRITE, 63, 63, 1, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,  63, 63, 0, 1, 1, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_UNUSED, 63, 63, 1, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_WRITE, 10,  9, 1, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_WRITE, 10, 10, 1, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_WRITE, 10, 11, 1, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_WRITE,  0,  0, 0, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,   0,  0, 0, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_STEP,   0,  0, 0, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,   9, 10, 0, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,  63, 63, 0, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_cfg(CFG_ACTIVE_WIDTH, 3));
    dir_rows.insert(dir_rows.size(), dir_cfg(CFG_ACTIVE_HEIGHT, 2));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,   1,  2, 0, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,   2,  0, 0, 1, 0, 1));
    dir_rows.insert(dir_rows.size(), dir_op(OP_WRITE,  0,  3, 1, 1, 0, 1));
    dir_rows.insert(dir_rows.size(), dir_op(OP_WRITE,  1,  1, 1, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_STEP,   0,  0, 0, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_cfg(CFG_ACTIVE_WIDTH, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,   0,  0, 0, 1, 0, 1));
    dir_rows.insert(dir_rows.size(), dir_op(OP_STEP,  63, 63, 1, 1, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_cfg(CFG_ACTIVE_WIDTH, 127));
    dir_rows.insert(dir_rows.size(), dir_cfg(CFG_ACTIVE_HEIGHT, 127));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,  10, 10, 0, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,  63, 63, 0, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_STEP,   0,  0, 0, 0, 0, 0));
    dir_rows.insert(dir_rows.size(), dir_op(OP_READ,  11, 10, 0, 0, 0, 0));

    phase_cols = '{64, 1, 127, 1, 64, 3, 0, 0, 0};
    phase_rows = '{64, 1, 127, 64, 1, 3, 0, 0, 0};
    for (int p = 6; p < 9; p++) begin
      phase_cols[p] = $urandom_range(127);
      phase_rows[p] = $urandom_range(127);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg)
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
      else
        issue(dir_rows[i].item, dir_rows[i].pinned, dir_rows[i].res);
    end

    for (int p = 0; p < 9; p++) begin
      write_reg(CFG_ACTIVE_WIDTH, phase_cols[p][6:0]);
      write_reg(CFG_ACTIVE_HEIGHT, phase_rows[p][6:0]);
      steady = (p == 3 || p == 7);
      useful = 0;
      while (useful < 64) begin
        it = rand_item();
        if (it.op != OP_UNUSED) useful++;
        issue(it, 1'b0, '0);
      end
    end
    steady = 0;

    start <= 1'b0;
    do @(posedge clk_i); while (cell_results_q.size() != 0);
    repeat (80) @(posedge clk_i);

    $display("Covered %0d writes, %0d reads (%0d live), %0d generations, %0d unused ops",
             n_writes, n_reads, n_live_reads, n_steps, n_unused);
    $display("%0d accesses fell outside the active grid; %0d mismatches", n_oor, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
